### src/utf16_surrogate_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// UTF-16 surrogate decoder assertion macros
// Shared assertion forms; every user module has clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef UTF16_SURROGATE_DECODER_UNIT_MACROS_SVH
`define UTF16_SURROGATE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset
`define USD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usd assertion failed");

// Next-cycle implication, held off during reset
`define USD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usd assertion failed");

`endif

### src/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Types and constants shared by the UTF-16 surrogate decoder modules.
// ----------------------------------------------------------------------------
package usd_pkg;

  localparam int UNIT_W = 16;
  localparam int CHAR_W = 21;
  localparam int SURR_BITS_W = 10;

  localparam logic [UNIT_W-1:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [UNIT_W-1:0] HI_SURR_LAST  = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LO_SURR_FIRST = 16'hDC00;
  localparam logic [UNIT_W-1:0] LO_SURR_LAST  = 16'hDFFF;
  localparam logic [UNIT_W-1:0] REPLACEMENT   = 16'hFFFD;
  localparam logic [CHAR_W-1:0] SUPP_BASE     = 21'h010000;

  // Job queue between classifier and result sequencer
  localparam int JQ_DEPTH = 2;
  localparam int JQ_AW    = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  // One classified input unit: one or two results
  typedef struct packed {
    logic [CHAR_W-1:0] first;
    logic [UNIT_W-1:0] second;
    logic              two;
    logic              last;
  } job_t;

endpackage

### src/usd_front.sv
// ----------------------------------------------------------------------------
// usd_front
// Accepts code units, tracks the pending high surrogate and emits jobs.
// ----------------------------------------------------------------------------
`include "utf16_surrogate_decoder_unit_macros.svh"

module usd_front import usd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              last_unit,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              jq_full,
  output logic              job_push,
  output job_t              job
);

  logic                   keep_surrogates;
  logic                   pending_valid;
  logic                   pending_valid_next;
  logic [SURR_BITS_W-1:0] pending_bits;
  logic [SURR_BITS_W-1:0] pending_bits_next;
  logic                   accept;
  logic                   is_hi;
  logic                   is_lo;
  logic                   has_job;

  assign full      = jq_full;
  assign cfg_ready = 1'b1;
  assign accept    = push && !jq_full;
  assign job_push  = accept && has_job;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_surrogates <= 1'b0;
    end else if (cfg_valid) begin
      keep_surrogates <= cfg_data;
    end
  end

  // Unit classification
  always_comb begin
    is_hi = code_unit inside {[HI_SURR_FIRST:HI_SURR_LAST]};
    is_lo = code_unit inside {[LO_SURR_FIRST:LO_SURR_LAST]};
  end

  // Result selection and pending update
  always_comb begin
    logic              solo_has;
    logic [UNIT_W-1:0] solo_val;
    logic              solo_hold;

    // the unit decoded as if nothing were held
    solo_has  = 1'b1;
    solo_hold = 1'b0;
    solo_val  = code_unit;
    if (is_hi) begin
      if (last_unit) begin
        solo_val = REPLACEMENT;
      end else begin
        solo_has  = 1'b0;
        solo_hold = 1'b1;
      end
    end else if (is_lo) begin
      solo_val = REPLACEMENT;
    end

    has_job           = 1'b1;
    job.first         = {{(CHAR_W-UNIT_W){1'b0}}, solo_val};
    job.second        = solo_val;
    job.two           = 1'b0;
    job.last          = last_unit;
    pending_valid_next = 1'b0;
    pending_bits_next  = '0;

    if (pending_valid && is_lo) begin
      if (keep_surrogates) begin
        job.first  = {{(CHAR_W-UNIT_W){1'b0}}, HI_SURR_FIRST[UNIT_W-1:SURR_BITS_W],
                      pending_bits};
        job.second = code_unit;
        job.two    = 1'b1;
      end else begin
        job.first = {{(CHAR_W-2*SURR_BITS_W){1'b0}}, pending_bits,
                     code_unit[SURR_BITS_W-1:0]} + SUPP_BASE;
      end
    end else if (pending_valid) begin
      // broken pair: replacement, then the new unit on its own
      job.first = {{(CHAR_W-UNIT_W){1'b0}}, REPLACEMENT};
      job.two   = solo_has;
      pending_valid_next = solo_hold;
      pending_bits_next  = code_unit[SURR_BITS_W-1:0];
    end else begin
      has_job            = solo_has;
      pending_valid_next = solo_hold;
      pending_bits_next  = code_unit[SURR_BITS_W-1:0];
    end
  end

  // Pending high surrogate
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_bits  <= '0;
    end else if (accept) begin
      pending_valid <= pending_valid_next;
      pending_bits  <= pending_bits_next;
    end
  end

  `USD_ASSERT_NEXT(a_end_clears_pending, accept && last_unit, !pending_valid)
  `USD_ASSERT_IMP(a_last_makes_job, accept && last_unit, job_push)
  `USD_ASSERT_IMP(a_hold_no_second, job_push && pending_valid_next, !job.last)

endmodule

### src/usd_fifo.sv
// ----------------------------------------------------------------------------
// usd_fifo
// Short job queue decoupling the classifier from the result sequencer.
// ----------------------------------------------------------------------------
`include "utf16_surrogate_decoder_unit_macros.svh"

module usd_fifo import usd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic jq_full,
  input  logic rd_en,
  output job_t rd_job,
  output logic jq_empty
);

  job_t             mem [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr;
  logic [JQ_AW-1:0] rd_ptr;
  logic [JQ_CW-1:0] count;

  assign jq_full  = (count == JQ_CW'(JQ_DEPTH));
  assign jq_empty = (count == '0);
  assign rd_job   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  `USD_ASSERT_IMP(a_no_overflow, wr_en, !jq_full)
  `USD_ASSERT_IMP(a_no_underflow, rd_en, !jq_empty)
  `USD_ASSERT_IMP(a_count_range, 1'b1, count <= JQ_CW'(JQ_DEPTH))

endmodule

### src/usd_back.sv
// ----------------------------------------------------------------------------
// usd_back
// Expands jobs into one or two results held in an output register.
// ----------------------------------------------------------------------------
`include "utf16_surrogate_decoder_unit_macros.svh"

module usd_back import usd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  job_t              rd_job,
  input  logic              jq_empty,
  output logic              rd_en,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] char_value,
  output logic              run_end,
  output logic              string_end
);

  logic out_valid;
  logic sub;
  logic load;

  assign empty = !out_valid;
  assign load  = !jq_empty && (!out_valid || pop);
  assign rd_en = load && (sub || !rd_job.two);

  // Result sequencing control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= !sub && rd_job.two;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (sub) begin
        char_value <= {{(CHAR_W-UNIT_W){1'b0}}, rd_job.second};
        run_end    <= 1'b1;
        string_end <= rd_job.last;
      end else begin
        char_value <= rd_job.first;
        run_end    <= !rd_job.two;
        string_end <= !rd_job.two && rd_job.last;
      end
    end
  end

  `USD_ASSERT_IMP(a_sub_has_job, sub, !jq_empty)
  `USD_ASSERT_IMP(a_split_pending, out_valid && !run_end, sub)
  `USD_ASSERT_IMP(a_string_end_run, out_valid && string_end, run_end)

endmodule

### src/utf16_surrogate_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_surrogate_decoder_unit
// UTF-16 to UTF-32 stream decoder with U+FFFD replacement; keep_surrogates passes valid pairs through as two units.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive code_unit/last_unit and raise push; the unit is taken
//   when full is low. Result queue: while empty is low, char_value, run_end
//   and string_end hold the oldest result; pop takes it.
//   cfg_valid/cfg_data set keep_surrogates (cfg_ready is always high); write
//   it only while no unit is in flight.
// Path: a unit's job is written into the job queue, then loaded into the result register.
// Throughput: one unit per cycle while pop keeps up, limited by the result register
//   which shows one result per cycle; a unit giving two results shows them in turn.
//   A leading high surrogate gives no result.
// Reset (rst, synchronous): clears the held surrogate, the job queue, the
//   result register and keep_surrogates.
// Stall: when pop stays low the result register holds, the two-entry job
//   queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module utf16_surrogate_decoder_unit import usd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [UNIT_W-1:0] code_unit,
  input  logic              last_unit,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] char_value,
  output logic              run_end,
  output logic              string_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  job_t wr_job;
  job_t rd_job;
  logic job_push;
  logic jq_full;
  logic jq_empty;
  logic rd_en;

  // Classifier
  usd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .jq_full   (jq_full),
    .job_push  (job_push),
    .job       (wr_job)
  );

  // Job queue
  usd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (wr_job),
    .jq_full  (jq_full),
    .rd_en    (rd_en),
    .rd_job   (rd_job),
    .jq_empty (jq_empty)
  );

  // Result sequencer
  usd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_job     (rd_job),
    .jq_empty   (jq_empty),
    .rd_en      (rd_en),
    .empty      (empty),
    .pop        (pop),
    .char_value (char_value),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule
